[rtl/tcc_pkg.sv]
// Shared types and constants for the text console cell engine.
// Used by every module in rtl/ except tcc_ram. No dependencies.
package tcc_pkg;

    // Screen geometry
    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int DEPTH   = ROWS * COLUMNS;
    localparam int ADDR_W  = $clog2(DEPTH);

    // Field widths
    localparam int ROW_W = 5;
    localparam int COL_W = 7;
    localparam int CH_W  = 8;

    localparam logic [CH_W-1:0] NEWLINE = 8'd10;
    localparam logic [CH_W-1:0] CH_NONE = 8'd0;

    // Command codes
    localparam logic CMD_PUT  = 1'b0;
    localparam logic CMD_READ = 1'b1;

    typedef enum logic [2:0] {
        ACT_IGNORED = 3'd0,
        ACT_DRAW    = 3'd1,
        ACT_CLIP    = 3'd2,
        ACT_NEWLINE = 3'd3,
        ACT_SCROLL  = 3'd4,
        ACT_READ    = 3'd5
    } action_t;

    typedef struct packed {
        logic             cmd;
        logic [CH_W-1:0]  ch;
        logic [ROW_W-1:0] read_row;
        logic [COL_W-1:0] read_col;
    } item_t;

    typedef struct packed {
        action_t          action;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] column;
        logic [CH_W-1:0]  glyph;
    } result_t;

    // Decoded item handed from the cursor unit to the sequencer
    typedef struct packed {
        action_t           action;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  column;
        logic [CH_W-1:0]   glyph;
        logic              wr_en;
        logic              rd_en;
        logic [ADDR_W-1:0] addr;
    } plan_t;

endpackage

[rtl/tcc_ram.sv]
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module tcc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[rtl/tcc_cursor.sv]
// Cursor and row-ring state; decodes one item into a store access and result.
// Depends on tcc_pkg.
module tcc_cursor (
    input  logic           clk,
    input  logic           rst_n,
    input  tcc_pkg::item_t item,
    input  logic           take,
    output tcc_pkg::plan_t plan
);

    logic [tcc_pkg::ROW_W-1:0]  cur_row_reg, cur_row_next;
    logic [tcc_pkg::COL_W-1:0]  cur_col_reg, cur_col_next;
    logic [tcc_pkg::ROW_W-1:0]  base_reg, base_next;

    logic [tcc_pkg::ROW_W-1:0]  log_row;
    logic [tcc_pkg::COL_W-1:0]  log_col;
    logic [tcc_pkg::ROW_W:0]    row_sum;
    logic [tcc_pkg::ROW_W-1:0]  phys_row;
    logic                       in_range;
    logic                       last_row;
    logic                       room;

    assign last_row = (cur_row_reg >= tcc_pkg::ROW_W'(tcc_pkg::ROWS - 1));
    assign room     = (cur_col_reg <  tcc_pkg::COL_W'(tcc_pkg::COLUMNS - 1));
    assign in_range = ({1'b0, item.read_row} < (tcc_pkg::ROW_W + 1)'(tcc_pkg::ROWS))
                   && ({1'b0, item.read_col} < (tcc_pkg::COL_W + 1)'(tcc_pkg::COLUMNS));

    // Logical cell to touch: read target, top row on scroll, else cursor
    always_comb
    begin
        if (item.cmd == tcc_pkg::CMD_READ)
        begin
            log_row = item.read_row;
            log_col = item.read_col;
        end
        else if (item.ch == tcc_pkg::NEWLINE)
        begin
            log_row = '0;
            log_col = '0;
        end
        else
        begin
            log_row = cur_row_reg;
            log_col = cur_col_reg;
        end
    end

    // Logical to physical row through the ring base, then linear address
    assign row_sum  = {1'b0, log_row} + {1'b0, base_reg};
    assign phys_row = (row_sum >= (tcc_pkg::ROW_W + 1)'(tcc_pkg::ROWS))
                    ? tcc_pkg::ROW_W'(row_sum - (tcc_pkg::ROW_W + 1)'(tcc_pkg::ROWS))
                    : tcc_pkg::ROW_W'(row_sum);

    always_comb
    begin
        plan.addr   = tcc_pkg::ADDR_W'(phys_row) * tcc_pkg::ADDR_W'(tcc_pkg::COLUMNS)
                    + tcc_pkg::ADDR_W'(log_col);
        plan.action = tcc_pkg::ACT_IGNORED;
        plan.row    = cur_row_reg;
        plan.column = cur_col_reg;
        plan.glyph  = tcc_pkg::CH_NONE;
        plan.wr_en  = 1'b0;
        plan.rd_en  = 1'b0;
        cur_row_next = cur_row_reg;
        cur_col_next = cur_col_reg;
        base_next    = base_reg;

        if (item.cmd == tcc_pkg::CMD_READ)
        begin
            plan.action = tcc_pkg::ACT_READ;
            plan.row    = item.read_row;
            plan.column = item.read_col;
            plan.rd_en  = in_range;
        end
        else if (item.ch == tcc_pkg::CH_NONE)
        begin
            plan.action = tcc_pkg::ACT_IGNORED;
        end
        else if (item.ch == tcc_pkg::NEWLINE)
        begin
            cur_col_next = '0;
            plan.column  = '0;
            if (!last_row)
            begin
                cur_row_next = cur_row_reg + 1'b1;
                plan.action  = tcc_pkg::ACT_NEWLINE;
                plan.row     = cur_row_reg + 1'b1;
            end
            else
            begin
                // Top physical row becomes the new bottom row
                plan.action = tcc_pkg::ACT_SCROLL;
                plan.row    = tcc_pkg::ROW_W'(tcc_pkg::ROWS - 1);
                base_next   = (base_reg == tcc_pkg::ROW_W'(tcc_pkg::ROWS - 1))
                            ? '0 : base_reg + 1'b1;
            end
        end
        else if (room)
        begin
            plan.action  = tcc_pkg::ACT_DRAW;
            plan.glyph   = item.ch;
            plan.wr_en   = 1'b1;
            cur_col_next = cur_col_reg + 1'b1;
        end
        else
        begin
            plan.action = tcc_pkg::ACT_CLIP;
            plan.glyph  = item.ch;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_row_reg <= '0;
            cur_col_reg <= '0;
            base_reg    <= '0;
        end
        else if (take)
        begin
            cur_row_reg <= cur_row_next;
            cur_col_reg <= cur_col_next;
            base_reg    <= base_next;
        end
    end

endmodule

[rtl/text_console_cursor_scroll.sv]
// Text console cell engine: cursor, ring of rows in one RAM, result register.
// Reads wait for the registered RAM read, and a scroll zeroes the new bottom
// row before the next beat is taken; one beat in flight at a time.
// After reset the whole store is swept to zero before the first beat is taken.
// Depends on tcc_pkg, tcc_cursor, tcc_ram.
module text_console_cursor_scroll (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_stall,
    input  tcc_pkg::item_t   item,
    output logic             result_valid,
    input  logic             result_stall,
    output tcc_pkg::result_t result
);

    typedef enum logic [3:0] {
        S_CLEAR  = 4'b0001,
        S_IDLE   = 4'b0010,
        S_READ   = 4'b0100,
        S_SCROLL = 4'b1000
    } state_t;

    state_t                    state_reg, state_next;
    logic [tcc_pkg::ADDR_W-1:0] sweep_addr_reg, sweep_addr_next;
    logic [tcc_pkg::ADDR_W-1:0] sweep_last_reg, sweep_last_next;
    logic                       rd_hit_reg, rd_hit_next;
    logic                       result_valid_reg, result_valid_next;
    tcc_pkg::result_t           result_reg, result_next;

    tcc_pkg::plan_t             plan;
    logic                       take;
    logic                       out_free;

    logic                       ram_we;
    logic [tcc_pkg::ADDR_W-1:0] ram_waddr;
    logic [tcc_pkg::CH_W-1:0]   ram_wdata;
    logic                       ram_re;
    logic [tcc_pkg::CH_W-1:0]   ram_rdata;

    // Handshake: one beat at a time, only once the result slot frees up
    assign out_free     = !result_valid_reg || !result_stall;
    assign item_stall   = (state_reg != S_IDLE) || !out_free;
    assign take         = item_valid && !item_stall;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    tcc_cursor u_cursor (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (item),
        .take  (take),
        .plan  (plan)
    );

    tcc_ram #(
        .WIDTH (tcc_pkg::CH_W),
        .DEPTH (tcc_pkg::DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (plan.addr),
        .rdata (ram_rdata)
    );

    // Sequencer: clear sweeps, store access, result register
    always_comb
    begin
        state_next        = state_reg;
        sweep_addr_next   = sweep_addr_reg;
        sweep_last_next   = sweep_last_reg;
        rd_hit_next       = rd_hit_reg;
        result_valid_next = result_valid_reg && result_stall;
        result_next       = result_reg;
        ram_we            = 1'b0;
        ram_waddr         = plan.addr;
        ram_wdata         = item.ch;
        ram_re            = 1'b0;

        case (state_reg)
            S_CLEAR, S_SCROLL:
            begin
                ram_we    = 1'b1;
                ram_waddr = sweep_addr_reg;
                ram_wdata = '0;
                if (sweep_addr_reg == sweep_last_reg)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    sweep_addr_next = sweep_addr_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                if (take)
                begin
                    result_next.action = plan.action;
                    result_next.row    = plan.row;
                    result_next.column = plan.column;
                    result_next.glyph  = plan.glyph;
                    ram_we             = plan.wr_en;
                    ram_re             = plan.rd_en;
                    if (plan.action == tcc_pkg::ACT_READ)
                    begin
                        // Glyph arrives next cycle
                        rd_hit_next = plan.rd_en;
                        state_next  = S_READ;
                    end
                    else
                    begin
                        result_valid_next = 1'b1;
                        if (plan.action == tcc_pkg::ACT_SCROLL)
                        begin
                            sweep_addr_next = plan.addr;
                            sweep_last_next = plan.addr
                                            + tcc_pkg::ADDR_W'(tcc_pkg::COLUMNS - 1);
                            state_next      = S_SCROLL;
                        end
                    end
                end
            end
            S_READ:
            begin
                result_next.glyph = rd_hit_reg ? ram_rdata : tcc_pkg::CH_NONE;
                result_valid_next = 1'b1;
                state_next        = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_CLEAR;
            sweep_addr_reg   <= '0;
            sweep_last_reg   <= tcc_pkg::ADDR_W'(tcc_pkg::DEPTH - 1);
            rd_hit_reg       <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            sweep_addr_reg   <= sweep_addr_next;
            sweep_last_reg   <= sweep_last_next;
            rd_hit_reg       <= rd_hit_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

endmodule

[rtl/tcc_checker.sv]
// Port-level checks for the text console cell engine, bound to the top level.
// Depends on tcc_pkg and text_console_cursor_scroll.
module tcc_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             item_valid,
    input logic             item_stall,
    input tcc_pkg::item_t   item,
    input logic             result_valid,
    input logic             result_stall,
    input tcc_pkg::result_t result
);

    // Held result beat stays put
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("result beat changed while stalled");

    // Scroll always leaves cursor at start of bottom row
    a_scroll: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.action == tcc_pkg::ACT_SCROLL)
        |-> (result.row == tcc_pkg::ROW_W'(tcc_pkg::ROWS - 1))
            && (result.column == '0) && (result.glyph == '0))
        else $error("bad scroll beat");

    // Out-of-range read returns blank
    a_read_oob: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.action == tcc_pkg::ACT_READ)
        && (({1'b0, result.row} >= (tcc_pkg::ROW_W + 1)'(tcc_pkg::ROWS))
            || ({1'b0, result.column} >= (tcc_pkg::COL_W + 1)'(tcc_pkg::COLUMNS)))
        |-> (result.glyph == '0))
        else $error("out-of-range read returned data");

    // Drawn cells never land in the last column and are neither NUL nor newline
    a_draw: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.action == tcc_pkg::ACT_DRAW)
        |-> (result.column < tcc_pkg::COL_W'(tcc_pkg::COLUMNS - 1))
            && (result.glyph != tcc_pkg::CH_NONE) && (result.glyph != tcc_pkg::NEWLINE))
        else $error("bad draw beat");

endmodule

bind text_console_cursor_scroll tcc_checker u_tcc_checker (.*);
